>>> design/plm_pkg.sv
`timescale 1ns / 1ps

package plm_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 16;
    localparam int LEVEL_W  = 7;
    localparam int COUNT_W  = 2;

    // Shared multiply-add unit widths
    localparam int MAC_A_W = 22;
    localparam int MAC_B_W = 8;
    localparam int MAC_W   = MAC_A_W + MAC_B_W;
    localparam int ACC_W   = 22;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_FULL = 2'd2;

    // Constant multiplier operands
    localparam logic [MAC_B_W-1:0] MUL_LEVEL_MAX = 8'd100;
    localparam logic [MAC_B_W-1:0] MUL_OLD       = 8'd7;
    localparam logic [MAC_B_W-1:0] MUL_NEW       = 8'd3;
    localparam logic [MAC_B_W-1:0] MUL_DECAY     = 8'd8;
    // x / 10 == (x * 205) >> 11 for x <= 1028
    localparam logic [MAC_B_W-1:0] MUL_RECIP10   = 8'd205;
    localparam int                 RECIP10_SHIFT = 11;

    localparam int                 FS_SHIFT   = 15;
    localparam logic [15:0]        FULL_SCALE = 16'd32767;

    // Input kinds
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Register indexes
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_HOLD   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEAK,
        ST_OLD,
        ST_NEW,
        ST_DECAY,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [MAC_A_W-1:0] a;
        logic [MAC_B_W-1:0] b;
        logic [ACC_W-1:0]   c;
    } mac_op_t;

    // x / 32767 for x < 2^22: x = q0*32767 + (lo + q0), one correction step
    function automatic logic [LEVEL_W-1:0] div_full_scale(input logic [ACC_W-1:0] x);
        logic [ACC_W-FS_SHIFT-1:0] q0;
        logic [15:0]               r;
        logic [LEVEL_W:0]          q;
        q0 = x[ACC_W-1:FS_SHIFT];
        r  = {1'b0, x[FS_SHIFT-1:0]} + 16'(q0);
        q  = {1'b0, q0} + ((r >= FULL_SCALE) ? 8'd1 : 8'd0);
        if (q > {1'b0, LEVEL_MAX}) begin
            q = {1'b0, LEVEL_MAX};
        end
        return q[LEVEL_W-1:0];
    endfunction

endpackage

>>> design/mic_peak_level_meter.sv
`timescale 1ns / 1ps

// Microphone peak level meter. Sample transfers (tuser = 0) fold the sample
// magnitude into a running peak. Query transfers (tuser = 1) return one
// result: 0 when disabled, the held level when less than hold_ms has passed
// since the last refresh (both posted to the output register on acceptance),
// otherwise a refreshed level. A refresh runs on one shared multiply-add unit
// and takes five steps with at least two samples (peak*100, old*7, +fresh*3,
// *205, write) or three for a decay (old*8, *205, write) before it posts its
// result; the block then returns to idle, ready for the next input transfer.
// The input side stays not ready while a refresh runs; a query also waits for
// the output register to be free, samples do not.
module mic_peak_level_meter (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] sample, [47:16] now_ms
    input  logic        s_tuser,   // [0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] level, [7] zero
    output logic        m_tuser,   // [0] refreshed
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import plm_pkg::*;

    state_t               state_reg, state_next;
    logic [SAMPLE_W-1:0]  peak_reg, peak_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [LEVEL_W-1:0]   held_reg, held_next;
    logic [TIME_W-1:0]    last_reg, last_next;
    logic                 enable_reg;
    logic [HOLD_W-1:0]    hold_reg;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [LEVEL_W-1:0]   fresh_reg, fresh_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic                 m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0]   out_level_reg, out_level_next;
    logic                 out_fresh_reg, out_fresh_next;

    mac_op_t              mac_op;
    logic [MAC_W-1:0]     mac_result;

    logic                 s_xfer;
    logic [SAMPLE_W-1:0]  in_sample;
    logic [TIME_W-1:0]    in_now;
    logic [SAMPLE_W-1:0]  mag;
    logic [TIME_W-1:0]    elapsed;
    logic [LEVEL_W-1:0]   new_level;

    plm_mac u_mac (
        .op     (mac_op),
        .result (mac_result)
    );

    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_now    = s_tdata[SAMPLE_W +: TIME_W];
    assign mag       = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
    assign elapsed   = in_now - last_reg;

    assign s_tready  = (state_reg == ST_IDLE) &&
                       (!m_valid_reg || m_tready || s_tuser == CMD_SAMPLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, out_level_reg};
    assign m_tuser   = out_fresh_reg;

    // scaled accumulator holds (sum * 205); level is sum / 10
    always_comb begin
        new_level = acc_reg[RECIP10_SHIFT +: LEVEL_W];
        if (new_level > LEVEL_MAX) begin
            new_level = LEVEL_MAX;
        end
    end

    always_comb begin
        state_next     = state_reg;
        peak_next      = peak_reg;
        count_next     = count_reg;
        held_next      = held_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        fresh_next     = fresh_reg;
        now_next       = now_reg;
        m_valid_next   = m_valid_reg;
        out_level_next = out_level_reg;
        out_fresh_next = out_fresh_reg;
        mac_op         = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == CMD_SAMPLE) begin
                        if (mag > peak_reg) begin
                            peak_next = mag;
                        end
                        if (count_reg != COUNT_FULL) begin
                            count_next = count_reg + 1'b1;
                        end
                    end else if (!enable_reg) begin
                        m_valid_next   = 1'b1;
                        out_level_next = '0;
                        out_fresh_next = 1'b0;
                    end else if (elapsed < TIME_W'(hold_reg)) begin
                        m_valid_next   = 1'b1;
                        out_level_next = held_reg;
                        out_fresh_next = 1'b0;
                    end else begin
                        now_next   = in_now;
                        state_next = (count_reg == COUNT_FULL) ? ST_PEAK : ST_DECAY;
                    end
                end
            end
            ST_PEAK: begin
                mac_op.a   = MAC_A_W'(peak_reg);
                mac_op.b   = MUL_LEVEL_MAX;
                acc_next   = mac_result[ACC_W-1:0];
                state_next = ST_OLD;
            end
            ST_OLD: begin
                fresh_next = div_full_scale(acc_reg);
                mac_op.a   = MAC_A_W'(held_reg);
                mac_op.b   = MUL_OLD;
                acc_next   = mac_result[ACC_W-1:0];
                state_next = ST_NEW;
            end
            ST_NEW: begin
                mac_op.a   = MAC_A_W'(fresh_reg);
                mac_op.b   = MUL_NEW;
                mac_op.c   = acc_reg;
                acc_next   = mac_result[ACC_W-1:0];
                state_next = ST_SCALE;
            end
            ST_DECAY: begin
                mac_op.a   = MAC_A_W'(held_reg);
                mac_op.b   = MUL_DECAY;
                acc_next   = mac_result[ACC_W-1:0];
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                mac_op.a   = MAC_A_W'(acc_reg);
                mac_op.b   = MUL_RECIP10;
                acc_next   = mac_result[ACC_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                held_next      = new_level;
                last_next      = now_reg;
                peak_next      = '0;
                count_next     = '0;
                m_valid_next   = 1'b1;
                out_level_next = new_level;
                out_fresh_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            peak_reg    <= '0;
            count_reg   <= '0;
            held_reg    <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            peak_reg    <= peak_next;
            count_reg   <= count_next;
            held_reg    <= held_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            hold_reg   <= 16'd80;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_HOLD:   hold_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg       <= acc_next;
        fresh_reg     <= fresh_next;
        now_reg       <= now_next;
        out_level_reg <= out_level_next;
        out_fresh_reg <= out_fresh_next;
    end

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= LEVEL_MAX)
        else $error("held level above full scale");

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_FULL)
        else $error("sample count past saturation");

    a_peak_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser == CMD_SAMPLE) |=> peak_reg >= $past(peak_reg))
        else $error("peak dropped on a sample");

    a_refresh_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> (peak_reg == '0 && count_reg == '0 && m_valid_reg
                                    && out_fresh_reg))
        else $error("refresh did not clear peak and post result");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted during refresh");

endmodule

>>> design/plm_mac.sv
`timescale 1ns / 1ps

module plm_mac (
    input  plm_pkg::mac_op_t               op,
    output logic [plm_pkg::MAC_W-1:0]      result
);
    import plm_pkg::*;

    assign result = (op.a * op.b) + MAC_W'(op.c);

endmodule

>>> verif/tb_mic_peak_level_meter.sv
`timescale 1ns / 1ps

module tb_mic_peak_level_meter;
    import plm_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               refreshed;
    } level_result_t;

    // Tracks the meter state and the level answers still owed by the block
    class meter_scoreboard;
        logic               enabled;
        logic [HOLD_W-1:0]  hold;
        logic [15:0]        peak;
        logic [COUNT_W-1:0] count;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  last_ms;
        level_result_t      levels_due[$];
        int mismatches, samples, queries, refreshes, held, muted, reg_writes;

        function new();
            enabled    = 1'b1;
            hold       = 16'd80;
            peak       = '0;
            count      = '0;
            level      = '0;
            last_ms    = '0;
            mismatches = 0;
            samples    = 0;
            queries    = 0;
            refreshes  = 0;
            held       = 0;
            muted      = 0;
            reg_writes = 0;
        endfunction

        function void set_reg(input logic idx, input logic [15:0] val);
            if (idx == REG_ENABLE) begin
                enabled = val[0];
            end else begin
                hold = val;
            end
            reg_writes++;
        endfunction

        function logic [LEVEL_W-1:0] next_level();
            int unsigned old_lvl, pk, fresh, lvl;
            old_lvl = level;
            pk      = peak;
            if (count < COUNT_FULL) begin
                lvl = old_lvl * 8 / 10;
            end else begin
                fresh = pk * 100 / 32767;
                if (fresh > 100) begin
                    fresh = 100;
                end
                lvl = (old_lvl * 7 + fresh * 3) / 10;
            end
            if (lvl > 100) begin
                lvl = 100;
            end
            return lvl[LEVEL_W-1:0];
        endfunction

        function void note_item(input logic cmd, input logic [15:0] smp,
                                input logic [TIME_W-1:0] now);
            logic [15:0]       mag;
            logic [TIME_W-1:0] elapsed;
            level_result_t     r;
            if (cmd == CMD_SAMPLE) begin
                samples++;
                // two's complement magnitude; the most negative code gives 32768
                mag = smp[15] ? (~smp + 16'd1) : smp;
                if (mag > peak) begin
                    peak = mag;
                end
                if (count < COUNT_FULL) begin
                    count++;
                end
                return;
            end
            queries++;
            if (!enabled) begin
                r.level     = '0;
                r.refreshed = 1'b0;
                muted++;
            end else begin
                elapsed = now - last_ms;
                if (elapsed < {16'd0, hold}) begin
                    r.level     = level;
                    r.refreshed = 1'b0;
                    held++;
                end else begin
                    last_ms     = now;
                    level       = next_level();
                    peak        = '0;
                    count       = '0;
                    r.level     = level;
                    r.refreshed = 1'b1;
                    refreshes++;
                end
            end
            levels_due.push_back(r);
        endfunction

        function void check_level(input logic [7:0] tdata, input logic tuser);
            level_result_t want;
            if (levels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with no query waiting: tdata=%0d refreshed=%0b",
                             $time, tdata, tuser);
                end
                return;
            end
            want = levels_due.pop_front();
            if (tdata !== {1'b0, want.level} || tuser !== want.refreshed) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: expected level=%0d refreshed=%0b, got tdata=%0d refreshed=%0b",
                             $time, want.level, want.refreshed, tdata, tuser);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // [15:0] sample, [47:16] now_ms
    logic        s_tuser;    // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;    // [6:0] level, [7] zero
    logic        m_tuser;    // [0] refreshed
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    logic tx_idle_on;
    logic rx_idle_on;

    meter_scoreboard sb;

    mic_peak_level_meter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= !rx_idle_on || ($urandom_range(0, 99) >= 32);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.set_reg(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                sb.note_item(s_tuser, s_tdata[15:0], s_tdata[47:16]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_level(m_tdata, m_tuser);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [15:0] smp, input logic [31:0] now);
        while (tx_idle_on && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        // the unused field carries noise
        s_tdata  <= {(cmd == CMD_QUERY) ? now : 32'($urandom),
                     (cmd == CMD_SAMPLE) ? smp : 16'($urandom)};
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending until every owed level has come back, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.levels_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (12) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 200) - 100);
            3: return 16'($urandom_range(0, 4000));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0] clock_ms;
        int unsigned hold_now, n, k;
        logic        en_now;

        sb = new();
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= CMD_SAMPLE;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_ENABLE;
        cfg_data   <= '0;
        tx_idle_on <= 1'b1;
        rx_idle_on <= 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: hold boundary, full-scale peaks, decay, time going backwards
        send_item(CMD_QUERY, 16'h0000, 32'd0);
        send_item(CMD_QUERY, 16'h0000, 32'd80);
        send_item(CMD_SAMPLE, 16'h7FFF, 32'd0);
        send_item(CMD_SAMPLE, 16'h8000, 32'd0);
        send_item(CMD_QUERY, 16'h0000, 32'd159);
        send_item(CMD_QUERY, 16'h0000, 32'd160);
        send_item(CMD_SAMPLE, 16'h0000, 32'd0);
        send_item(CMD_QUERY, 16'h0000, 32'd240);
        send_item(CMD_SAMPLE, 16'hFFFF, 32'd0);
        send_item(CMD_SAMPLE, 16'h0001, 32'd0);
        send_item(CMD_QUERY, 16'h0000, 32'd320);
        send_item(CMD_SAMPLE, 16'h4000, 32'd0);
        send_item(CMD_SAMPLE, 16'hC000, 32'd0);
        send_item(CMD_QUERY, 16'h0000, 32'd10);
        send_item(CMD_QUERY, 16'h0000, 32'hFFFF_FFFF);
        wait_drained();
        // disabled: samples still count, queries answer zero
        write_reg(REG_ENABLE, 16'd0);
        send_item(CMD_SAMPLE, 16'd12345, 32'd0);
        send_item(CMD_QUERY, 16'h0000, 32'd0);
        wait_drained();
        write_reg(REG_ENABLE, 16'd1);
        write_reg(REG_HOLD, 16'd0);
        send_item(CMD_QUERY, 16'h0000, 32'hFFFF_FFFF);
        send_item(CMD_SAMPLE, 16'h8000, 32'd0);
        send_item(CMD_SAMPLE, 16'h7FFF, 32'd0);
        send_item(CMD_QUERY, 16'h0000, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(REG_HOLD, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'h1234, 32'd0);
        send_item(CMD_SAMPLE, 16'h8000, 32'd0);
        send_item(CMD_QUERY, 16'h0000, 32'h0000_FFFD);
        send_item(CMD_QUERY, 16'h0000, 32'h0000_FFFE);
        wait_drained();
        clock_ms = 32'h0000_FFFE;

        // random: bursts of samples followed by a query, one register setting per phase
        for (int p = 0; p < 7; p++) begin
            en_now = 1'b1;
            case (p)
                0: hold_now = 80;
                1: hold_now = 0;
                2: begin
                    en_now   = 1'b0;
                    hold_now = 40;
                end
                3: hold_now = 65535;
                4: hold_now = $urandom_range(1, 400);
                5: hold_now = 1;
                default: hold_now = $urandom_range(0, 65535);
            endcase
            write_reg(REG_ENABLE, {15'd0, en_now});
            write_reg(REG_HOLD, 16'(hold_now));
            tx_idle_on <= (p != 4);
            rx_idle_on <= (p != 4);
            n = 0;
            while (n < 190) begin
                case ($urandom_range(0, 9))
                    0: k = 0;
                    1: k = 1;
                    default: k = $urandom_range(2, 6);
                endcase
                repeat (k) begin
                    send_item(CMD_SAMPLE, pick_sample(), 32'd0);
                end
                case ($urandom_range(0, 9))
                    0: clock_ms = $urandom;    // arbitrary jump, either direction
                    1: clock_ms += hold_now;
                    2: clock_ms += (hold_now == 0) ? 0 : hold_now - 1;
                    default: clock_ms += $urandom_range(0, hold_now + hold_now / 2 + 3);
                endcase
                send_item(CMD_QUERY, 16'h0000, clock_ms);
                n += k + 1;
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        $display("Covered %0d samples and %0d queries: %0d refreshed, %0d held, %0d disabled.",
                 sb.samples, sb.queries, sb.refreshes, sb.held, sb.muted);
        $display("%0d register writes across directed and random phases, %0d mismatches.",
                 sb.reg_writes, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("mic_peak_level_meter test passed");
        end else begin
            $display("mic_peak_level_meter test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("mic_peak_level_meter test failed");
        $finish;
    end

endmodule

>>> filelist.f
design/plm_pkg.sv
design/plm_mac.sv
design/mic_peak_level_meter.sv
verif/tb_mic_peak_level_meter.sv
